FILE: rtl/oaeds_pkg.sv
// Package for the odd-ascending / even-descending sorter.
// Holds the data widths, the cell types and the sort-key function.
// No dependencies.
package oaeds_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned KEY_W  = DATA_W + 1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [KEY_W-1:0]         key_t;

	// one slot of the chain
	typedef struct packed {
		logic  valid;
		data_t value;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic load;
		logic drain;
	} cell_ctrl_t;

	// odd values first and rising, then even values falling: one unsigned ascending key
	function automatic key_t make_key(input data_t v);
		key_t k;
		if (v[0]) begin
			k = {1'b0, ~v[DATA_W-1], v[DATA_W-2:0]};
		end else begin
			k = {1'b1, v[DATA_W-1], ~v[DATA_W-2:0]};
		end
		return k;
	endfunction

endpackage

FILE: rtl/oaeds_if.sv
// Valid/ready channel interfaces for the sorter's input and result items.
// Depends on oaeds_pkg.
interface oaeds_in_if;
	import oaeds_pkg::*;
	logic  valid;
	logic  ready;
	data_t value;
	logic  is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface oaeds_out_if;
	import oaeds_pkg::*;
	logic  valid;
	logic  ready;
	data_t value_res;
	logic  is_final;
	logic  overflowed;

	modport source (output valid, output value_res, output is_final, output overflowed,
		input ready);
	modport sink   (input valid, input value_res, input is_final, input overflowed,
		output ready);
endinterface

FILE: rtl/oaeds_cell.sv
// One cell of the insertion-sort chain: holds one element, compares it with the
// broadcast item, and shifts towards the next cell on insert or towards cell 0 on drain.
// Depends on oaeds_pkg.
module oaeds_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  oaeds_pkg::cell_ctrl_t ctrl,
	input  oaeds_pkg::data_t    new_value,
	input  oaeds_pkg::key_t     new_key,
	input  oaeds_pkg::entry_t   prev_entry,
	input  logic                prev_ins,
	input  oaeds_pkg::entry_t   next_entry,
	output oaeds_pkg::entry_t   entry,
	output logic                ins
);
	import oaeds_pkg::*;

	logic  valid_q;
	data_t value_q;

	assign entry = '{valid: valid_q, value: value_q};
	assign ins   = ctrl.load && (!valid_q || (new_key < make_key(value_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= next_entry.valid;
		end else if (ins) begin
			valid_q <= prev_ins ? prev_entry.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			value_q <= next_entry.value;
		end else if (ins) begin
			value_q <= prev_ins ? prev_entry.value : new_value;
		end
	end

endmodule

FILE: rtl/odd_ascending_even_descending_sort.sv
// Top level of the odd-ascending / even-descending sorter: a chain of sort cells
// plus the fill counter, overflow flag and drain control.
// Depends on oaeds_pkg, oaeds_if.sv and oaeds_cell.
//
// Use: items arrive on in_ch (valid/ready), one element each, is_last on the final
// one. Each accepted item is written to its sorted place at the edge that accepts it, so
// collection runs at one item per cycle; every cell compares its element with the new
// item in the accepting cycle. At most MAX_ITEMS elements are kept; further items are
// dropped and the run carries overflowed = 1.
// The cycle after the item with is_last is accepted, results appear on out_ch: odd
// values rising, then even values falling, one per cycle while out_ch.ready is high,
// is_final on the last. A stall on out_ch simply holds the chain. in_ch.ready is low
// while a run is being emitted.
// Reset (arst_n low) empties the chain and clears the count and overflow flag.
module odd_ascending_even_descending_sort #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	oaeds_in_if.sink          in_ch,
	oaeds_out_if.source       out_ch
);
	import oaeds_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

	logic [CNT_W-1:0]     count_q;
	logic                 ovf_q;
	logic                 drain_q;
	logic                 in_acc;
	logic                 out_acc;
	key_t                 new_key;
	cell_ctrl_t           ctrl;
	entry_t               cells   [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] ins_vec;
	logic [MAX_ITEMS-1:0] valid_vec;

	assign in_ch.ready = !drain_q;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_ch.valid && out_ch.ready;
	assign new_key     = make_key(in_ch.value);
	assign ctrl.load   = in_acc && (count_q < CNT_W'(MAX_ITEMS));
	assign ctrl.drain  = out_acc;

	assign out_ch.valid      = drain_q;
	assign out_ch.value_res  = cells[0].value;
	assign out_ch.is_final   = !cells[1].valid;
	assign out_ch.overflowed = ovf_q;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_i;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_i = 1'b0;
		end else begin : g_body
			assign prev_e = cells[i-1];
			assign prev_i = ins_vec[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = cells[i+1];
		end

		oaeds_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (in_ch.value),
			.new_key    (new_key),
			.prev_entry (prev_e),
			.prev_ins   (prev_i),
			.next_entry (next_e),
			.entry      (cells[i]),
			.ins        (ins_vec[i])
		);

		assign valid_vec[i] = cells[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
		end else if (drain_q) begin
			if (out_acc && out_ch.is_final) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				drain_q <= 1'b0;
			end
		end else if (in_acc) begin
			if (ctrl.load) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
			if (in_ch.is_last) begin
				drain_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> cells[0].valid)
		else $error("result offered from an empty head cell");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> ($countones(valid_vec) == int'(count_q)))
		else $error("occupied cells disagree with fill count");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_ch.is_final) |=> (!out_ch.valid && valid_vec == '0))
		else $error("chain not empty after final result");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.is_last) |=> out_ch.valid)
		else $error("no run after last item");
`endif

endmodule
